### design/ctp_pkg.sv
// Content-Type parser package: payload structs, parse phases, field codes
// and character class helpers. No dependencies.
package ctp_pkg;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic [2:0] field_kind;
    logic       field_restart;
    logic [1:0] verdict;
    logic       end_mark;
  } out_t;

  typedef enum logic [3:0] {
    PH_LWS,
    PH_TYPE,
    PH_SUB0,
    PH_SUB,
    PH_SEP,
    PH_AFTSEMI,
    PH_NAME,
    PH_VAL0,
    PH_TOKVAL,
    PH_QUOTED,
    PH_ESC,
    PH_REJ
  } phase_t;

  localparam logic [1:0] TGT_NONE     = 2'd0;
  localparam logic [1:0] TGT_CHARSET  = 2'd1;
  localparam logic [1:0] TGT_BOUNDARY = 2'd2;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_TYPE     = 3'd1;
  localparam logic [2:0] KIND_SUB      = 3'd2;
  localparam logic [2:0] KIND_CHARSET  = 3'd3;
  localparam logic [2:0] KIND_BOUNDARY = 3'd4;

  localparam logic [1:0] VERD_PARSING = 2'd0;
  localparam logic [1:0] VERD_ACCEPT  = 2'd1;
  localparam logic [1:0] VERD_REJECT  = 2'd2;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_VCHAR_LO = 8'h21;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic [3:0] CHARSET_LEN  = 4'd7;
  localparam logic [3:0] BOUNDARY_LEN = 4'd8;
  localparam logic [3:0] NAME_LEN_MAX = 4'd15;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] name_len;
    logic       cs_cand;
    logic       bd_cand;
    logic [1:0] target;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:    PH_LWS,
    name_len: 4'd0,
    cs_cand:  1'b1,
    bd_cand:  1'b1,
    target:   TGT_NONE
  };

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_tchar(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c)
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B, 8'h2D, 8'h2E,
      8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
      default: r = (c >= 8'h30 && c <= 8'h39) || is_alpha(c);
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [7:0] charset_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h63;
      3'd1: r = 8'h68;
      3'd2: r = 8'h61;
      3'd3: r = 8'h72;
      3'd4: r = 8'h73;
      3'd5: r = 8'h65;
      3'd6: r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] boundary_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'h62;
      3'd1: r = 8'h6F;
      3'd2: r = 8'h75;
      3'd3: r = 8'h6E;
      3'd4: r = 8'h64;
      3'd5: r = 8'h61;
      3'd6: r = 8'h72;
      default: r = 8'h79;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] target_kind(input logic [1:0] tgt);
    logic [2:0] r;
    case (tgt)
      TGT_CHARSET:  r = KIND_CHARSET;
      TGT_BOUNDARY: r = KIND_BOUNDARY;
      default:      r = KIND_NONE;
    endcase
    return r;
  endfunction

endpackage

### design/ctp_step.sv
// Content-Type parser: one byte of grammar checking, field tagging and
// parameter name matching. Combinational. Depends on ctp_pkg.
module ctp_step (
  input  ctp_pkg::state_t st,
  input  ctp_pkg::in_t    din,
  output ctp_pkg::state_t st_nxt,
  output ctp_pkg::out_t   res
);

  logic [7:0]      c;
  logic [7:0]      lc;
  logic            tch;
  logic            ws;
  logic            qd;
  logic            last;
  logic [2:0]      tkind;
  ctp_pkg::phase_t np;
  logic [7:0]      ch;
  logic            vld;
  logic [2:0]      kind;
  logic            rstrt;
  logic [1:0]      tgt;
  logic [3:0]      base_len;
  logic            base_cs;
  logic            base_bd;
  logic            new_cs;
  logic            new_bd;
  logic [3:0]      new_len;
  logic            np_ok;

  always_comb begin
    c     = din.header_byte;
    last  = din.last_byte;
    lc    = ctp_pkg::to_lower(c);
    tch   = ctp_pkg::is_tchar(c);
    ws    = (c == ctp_pkg::CH_SP) || (c == ctp_pkg::CH_TAB);
    qd    = ws || ((c >= ctp_pkg::CH_VCHAR_LO) && (c != ctp_pkg::CH_DEL));
    tkind = ctp_pkg::target_kind(st.target);
    np    = ctp_pkg::PH_REJ;
    ch    = 8'h00;
    vld   = 1'b0;
    kind  = ctp_pkg::KIND_NONE;
    rstrt = 1'b0;
    tgt   = st.target;

    case (st.phase)
      ctp_pkg::PH_LWS: begin
        if (ws) begin
          np = ctp_pkg::PH_LWS;
        end else if (tch) begin
          np = ctp_pkg::PH_TYPE; ch = lc; vld = 1'b1;
          kind = ctp_pkg::KIND_TYPE; rstrt = 1'b1;
        end
      end
      ctp_pkg::PH_TYPE: begin
        if (tch) begin
          np = ctp_pkg::PH_TYPE; ch = lc; vld = 1'b1; kind = ctp_pkg::KIND_TYPE;
        end else if (c == ctp_pkg::CH_SLASH) begin
          np = ctp_pkg::PH_SUB0;
        end
      end
      ctp_pkg::PH_SUB0: begin
        if (tch) begin
          np = ctp_pkg::PH_SUB; ch = lc; vld = 1'b1;
          kind = ctp_pkg::KIND_SUB; rstrt = 1'b1;
        end
      end
      ctp_pkg::PH_SUB: begin
        if (tch) begin
          np = ctp_pkg::PH_SUB; ch = lc; vld = 1'b1; kind = ctp_pkg::KIND_SUB;
        end else if (ws) begin
          np = ctp_pkg::PH_SEP;
        end else if (c == ctp_pkg::CH_SEMI) begin
          np = ctp_pkg::PH_AFTSEMI;
        end
      end
      ctp_pkg::PH_TOKVAL: begin
        if (tch) begin
          np = ctp_pkg::PH_TOKVAL; kind = tkind;
          if (tkind != ctp_pkg::KIND_NONE) begin
            ch = c; vld = 1'b1;
          end
        end else if (ws) begin
          np = ctp_pkg::PH_SEP;
        end else if (c == ctp_pkg::CH_SEMI) begin
          np = ctp_pkg::PH_AFTSEMI;
        end
      end
      ctp_pkg::PH_SEP: begin
        if (ws) begin
          np = ctp_pkg::PH_SEP;
        end else if (c == ctp_pkg::CH_SEMI) begin
          np = ctp_pkg::PH_AFTSEMI;
        end
      end
      ctp_pkg::PH_AFTSEMI: begin
        if (ws || (c == ctp_pkg::CH_SEMI)) begin
          np = ctp_pkg::PH_AFTSEMI;
        end else if (tch) begin
          np = ctp_pkg::PH_NAME;
        end
      end
      ctp_pkg::PH_NAME: begin
        if ((c == ctp_pkg::CH_EQ) && !last) begin
          np = ctp_pkg::PH_VAL0;
          if (st.cs_cand && (st.name_len == ctp_pkg::CHARSET_LEN)) begin
            tgt = ctp_pkg::TGT_CHARSET;
          end else if (st.bd_cand && (st.name_len == ctp_pkg::BOUNDARY_LEN)) begin
            tgt = ctp_pkg::TGT_BOUNDARY;
          end else begin
            tgt = ctp_pkg::TGT_NONE;
          end
          kind  = ctp_pkg::target_kind(tgt);
          rstrt = (kind != ctp_pkg::KIND_NONE);
        end else if (tch) begin
          np = ctp_pkg::PH_NAME;
        end
      end
      ctp_pkg::PH_VAL0: begin
        if (c == ctp_pkg::CH_DQUOTE) begin
          np = ctp_pkg::PH_QUOTED;
        end else if (tch) begin
          np = ctp_pkg::PH_TOKVAL; kind = tkind;
          if (tkind != ctp_pkg::KIND_NONE) begin
            ch = c; vld = 1'b1;
          end
        end
      end
      ctp_pkg::PH_QUOTED: begin
        if (c == ctp_pkg::CH_DQUOTE) begin
          np = ctp_pkg::PH_SEP;
        end else if (c == ctp_pkg::CH_BSLASH) begin
          np = ctp_pkg::PH_ESC;
        end else if (qd) begin
          np = ctp_pkg::PH_QUOTED; kind = tkind;
          if (tkind != ctp_pkg::KIND_NONE) begin
            ch = c; vld = 1'b1;
          end
        end
      end
      ctp_pkg::PH_ESC: begin
        if (qd) begin
          np = ctp_pkg::PH_QUOTED; kind = tkind;
          if (tkind != ctp_pkg::KIND_NONE) begin
            ch = c; vld = 1'b1;
          end
        end
      end
      default: begin
        np = ctp_pkg::PH_REJ;
      end
    endcase

    // name matching; a name byte right after ';' starts a fresh name
    base_len = (st.phase == ctp_pkg::PH_AFTSEMI) ? 4'd0 : st.name_len;
    base_cs  = (st.phase == ctp_pkg::PH_AFTSEMI) ? 1'b1 : st.cs_cand;
    base_bd  = (st.phase == ctp_pkg::PH_AFTSEMI) ? 1'b1 : st.bd_cand;
    new_cs   = base_cs && (base_len < ctp_pkg::CHARSET_LEN) &&
               (ctp_pkg::charset_char(base_len[2:0]) == lc);
    new_bd   = base_bd && (base_len < ctp_pkg::BOUNDARY_LEN) &&
               (ctp_pkg::boundary_char(base_len[2:0]) == lc);
    new_len  = (base_len == ctp_pkg::NAME_LEN_MAX) ? base_len : base_len + 4'd1;

    if (np == ctp_pkg::PH_REJ) begin
      ch = 8'h00; vld = 1'b0; kind = ctp_pkg::KIND_NONE; rstrt = 1'b0;
    end

    np_ok = (np == ctp_pkg::PH_SUB) || (np == ctp_pkg::PH_SEP) ||
            (np == ctp_pkg::PH_AFTSEMI) || (np == ctp_pkg::PH_TOKVAL);

    st_nxt        = st;
    st_nxt.phase  = np;
    st_nxt.target = tgt;
    if (np == ctp_pkg::PH_NAME) begin
      st_nxt.name_len = new_len;
      st_nxt.cs_cand  = new_cs;
      st_nxt.bd_cand  = new_bd;
    end

    res.out_char      = ch;
    res.char_valid    = vld;
    res.field_kind    = kind;
    res.field_restart = rstrt;
    res.end_mark      = last;
    if (last) begin
      res.verdict = np_ok ? ctp_pkg::VERD_ACCEPT : ctp_pkg::VERD_REJECT;
      st_nxt      = ctp_pkg::STATE_RESET;
    end else begin
      res.verdict = (np == ctp_pkg::PH_REJ) ? ctp_pkg::VERD_REJECT
                                            : ctp_pkg::VERD_PARSING;
    end
  end

endmodule

### design/content_type_header_parser_core.sv
// Content-Type header parser top: input register, parser state, result register.
// A byte transferred in passes the input register, then the result register, to out_data.
// Throughput: one byte per cycle unless out_ready stalls; ctp_step is combinational.
// Reset (rst_n low, synchronous): both stages empty, parser in leading-whitespace phase.
// The state also returns to reset after every byte marked last_byte.
// Depends on ctp_pkg and ctp_step.
module content_type_header_parser_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ctp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ctp_pkg::out_t out_data
);

  logic            a_valid_r;
  logic            a_valid_nxt;
  ctp_pkg::in_t    a_data_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  ctp_pkg::out_t   out_data_r;
  ctp_pkg::state_t st_r;
  ctp_pkg::state_t st_nxt;
  ctp_pkg::state_t step_st;
  ctp_pkg::out_t   step_res;
  logic            adv;
  logic            fire;
  logic            in_xfer;

  ctp_step u_step (
    .st     (st_r),
    .din    (a_data_r),
    .st_nxt (step_st),
    .res    (step_res)
  );

  always_comb begin
    adv           = !out_valid_r || out_ready;
    fire          = a_valid_r && adv;
    in_ready      = !a_valid_r || adv;
    in_xfer       = in_valid && in_ready;
    a_valid_nxt   = in_xfer || (a_valid_r && !adv);
    out_valid_nxt = fire || (out_valid_r && !out_ready);
    st_nxt        = fire ? step_st : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= ctp_pkg::STATE_RESET;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_char_tagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.char_valid |-> out_data_r.field_kind != ctp_pkg::KIND_NONE)
    else $error("char_valid without a field kind");

  a_restart_tagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.field_restart |->
      out_data_r.field_kind != ctp_pkg::KIND_NONE)
    else $error("restart without a field kind");

  a_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.verdict == ctp_pkg::VERD_ACCEPT |-> out_data_r.end_mark)
    else $error("accept verdict before last byte");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.char_valid |-> out_data_r.out_char == 8'h00)
    else $error("untagged byte carries a character");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && a_data_r.last_byte |=> st_r == ctp_pkg::STATE_RESET)
    else $error("parser state not reset after last byte");

endmodule
